// ===== hdl/mtrr_pkg.sv =====
// Shared constants, types and command/status structs for the MTRR range decomposer.
// No dependencies; imported by every module of the block.
package mtrr_pkg;

  localparam int NUM_PAIRS = 8;                      // 2..16 base/mask pairs
  localparam int PAIR_W    = $clog2(NUM_PAIRS);
  localparam int TOM_W     = 16;
  localparam int ADDR_W    = 10;
  localparam int DATA_W    = 48;
  localparam int TYPE_W    = 3;

  localparam logic [ADDR_W-1:0] ADDR_FIRST    = 10'h200;
  localparam logic [TYPE_W-1:0] MEM_TYPE_RST  = 3'd6;
  localparam logic [PAIR_W-1:0] PAIR_LAST_RGN = PAIR_W'(NUM_PAIRS - 2);
  localparam logic [PAIR_W-1:0] PAIR_END      = PAIR_W'(NUM_PAIRS - 1);

  // kind of register write on the output
  typedef enum logic [1:0] {
    W_BASE,
    W_MASK,
    W_CLR_MASK,
    W_CLR_BASE
  } wsel_t;

  typedef struct packed {
    logic  load;          // start a run: base = 0, pair = 0, capture top
    logic  latch_size;    // register region size for the mask write
    logic  advance;       // base += size, pair++
    logic  step_pair;     // pair++ during clearing
    wsel_t wsel;
  } cmd_t;

  typedef struct packed {
    logic in_top_zero;      // requested top is zero
    logic next_below_top;   // base + size still short of top
    logic pair_last_region; // pair is the last one allowed to hold a region
    logic pair_end;         // pair is the final register pair
  } sts_t;

endpackage

// ===== hdl/mtrr_ctrl.sv =====
// Sequencer for the MTRR range decomposer: region writes, then clearing writes.
// Depends on mtrr_pkg; drives mtrr_dpath through cmd_t, reads sts_t.
module mtrr_ctrl import mtrr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic out_run_last,
  output logic out_status,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_MASK,
    S_CLR_MASK,
    S_CLR_BASE
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r != S_IDLE);
  assign take      = out_valid && out_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.wsel       = W_BASE;
    out_run_last   = 1'b0;
    out_status     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_top_zero ? S_CLR_MASK : S_BASE;
        end
      end
      S_BASE: begin
        cmd.wsel = W_BASE;
        if (take) begin
          cmd.latch_size = 1'b1;
          state_nxt      = S_MASK;
        end
      end
      S_MASK: begin
        cmd.wsel = W_MASK;
        // out of pairs with span left over: run ends here
        out_run_last = sts.next_below_top && sts.pair_last_region;
        out_status   = out_run_last;
        if (take) begin
          cmd.advance = 1'b1;
          if (!sts.next_below_top)      state_nxt = S_CLR_MASK;
          else if (sts.pair_last_region) state_nxt = S_IDLE;
          else                          state_nxt = S_BASE;
        end
      end
      S_CLR_MASK: begin
        cmd.wsel = W_CLR_MASK;
        if (take) state_nxt = S_CLR_BASE;
      end
      S_CLR_BASE: begin
        cmd.wsel     = W_CLR_BASE;
        out_run_last = sts.pair_end;
        if (take) begin
          if (sts.pair_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.step_pair = 1'b1;
            state_nxt     = S_CLR_MASK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/mtrr_dpath.sv =====
// Datapath for the MTRR range decomposer: base, top, pair and size registers,
// region size selection and register word formatting. Depends on mtrr_pkg.
module mtrr_dpath import mtrr_pkg::*; (
  input  logic              clk,
  input  logic [TOM_W-1:0]  in_tom_units,
  input  logic [TYPE_W-1:0] mem_type,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic [ADDR_W-1:0] out_reg_addr,
  output logic [DATA_W-1:0] out_reg_data
);

  logic [TOM_W-1:0]  top_r;
  logic [TOM_W-1:0]  base_r;
  logic [TOM_W-1:0]  size_r;
  logic [PAIR_W-1:0] pair_r;

  logic [TOM_W-1:0]  low_size;
  logic [TOM_W-1:0]  rem;
  logic [TOM_W-1:0]  high_size;
  logic [TOM_W:0]    low_limit;
  logic              use_high;
  logic [TOM_W-1:0]  sel_size;
  logic [TOM_W:0]    next_base;
  logic              odd;

  // lowest set bit of base
  assign low_size  = base_r & (~base_r + TOM_W'(1));
  assign low_limit = {1'b0, base_r} + {1'b0, low_size};
  assign rem       = top_r - base_r;

  // highest set bit of the remaining span
  always_comb begin
    high_size = '0;
    for (int b = 0; b < TOM_W; b++) begin
      if (rem[b]) high_size = TOM_W'(1) << b;
    end
  end

  assign use_high = (base_r == '0) || (low_limit > {1'b0, top_r});
  assign sel_size = use_high ? high_size : low_size;
  assign next_base = {1'b0, base_r} + {1'b0, size_r};

  assign sts.in_top_zero      = (in_tom_units == '0);
  assign sts.next_below_top   = (next_base < {1'b0, top_r});
  assign sts.pair_last_region = (pair_r == PAIR_LAST_RGN);
  assign sts.pair_end         = (pair_r == PAIR_END);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top_r  <= in_tom_units;
      base_r <= '0;
      pair_r <= '0;
    end
    if (cmd.latch_size) size_r <= sel_size;
    if (cmd.advance) begin
      base_r <= next_base[TOM_W-1:0];
      pair_r <= pair_r + PAIR_W'(1);
    end
    if (cmd.step_pair) pair_r <= pair_r + PAIR_W'(1);
  end

  // mask registers sit at odd addresses
  assign odd = (cmd.wsel == W_MASK) || (cmd.wsel == W_CLR_MASK);
  assign out_reg_addr = ADDR_FIRST + ADDR_W'({pair_r, odd});

  always_comb begin
    case (cmd.wsel)
      W_BASE:  out_reg_data = {16'h0000, base_r, 13'd0, mem_type};
      W_MASK:  out_reg_data = {16'hFFFF, ~(size_r - TOM_W'(1)), 4'd0, 1'b1, 11'd0};
      default: out_reg_data = '0;
    endcase
  end

endmodule

// ===== hdl/mtrr_range_decomposer_unit.sv =====
// Top level of the MTRR range decomposer: config register, controller, datapath.
// Depends on mtrr_pkg, mtrr_ctrl and mtrr_dpath.
//
// One request carries a top of memory in 64 KiB units. The block covers 0 up
// to that top with naturally aligned power-of-two regions and emits one result
// per register write: a base word then a mask word for each region, starting at
// 0x200, at most NUM_PAIRS-1 regions. When the span is covered, the remaining
// pairs are cleared mask first, then base, through the last pair, and the run
// ends with status pass; when regions run out first, the run ends on the last
// mask write with status out of resources. run_last marks the final write.
// Each write is held while out_ready is low and the sequencer moves on once it
// is taken; a run is 2*NUM_PAIRS writes when covered (2*(NUM_PAIRS-1) when out
// of resources). The sequencer handles one request at a time and in_ready is
// high only between runs. Region size is picked in the base write cycle
// (lowest set bit of the base, or highest set bit of the span left).
// cfg_mem_type sets the type code in every base word (reset: 6, write-back);
// write it only between runs.
module mtrr_range_decomposer_unit import mtrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TOM_W-1:0]  in_tom_units,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_reg_addr,
  output logic [DATA_W-1:0] out_reg_data,
  output logic              out_run_last,
  output logic              out_status,
  input  logic              cfg_we,
  input  logic [TYPE_W-1:0] cfg_mem_type
);

  logic [TYPE_W-1:0] mem_type_r;
  cmd_t              cmd;
  sts_t              sts;

  // memory type register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_type_r <= MEM_TYPE_RST;
    end else if (cfg_we) begin
      mem_type_r <= cfg_mem_type;
    end
  end

  mtrr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_run_last (out_run_last),
    .out_status   (out_status),
    .cmd          (cmd),
    .sts          (sts)
  );

  // payload is formed from datapath registers, held while a write is stalled
  mtrr_dpath u_dpath (
    .clk          (clk),
    .in_tom_units (in_tom_units),
    .mem_type     (mem_type_r),
    .cmd          (cmd),
    .sts          (sts),
    .out_reg_addr (out_reg_addr),
    .out_reg_data (out_reg_data)
  );

endmodule

// ===== tb/mtrr_range_decomposer_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench for mtrr_range_decomposer_unit: directed and random top-of-memory requests.
// Depends on mtrr_pkg and the mtrr_range_decomposer_unit RTL; needs no other files.
module mtrr_range_decomposer_unit_tb;
  import mtrr_pkg::*;

  // status codes carried on the last write of a run
  localparam logic ST_PASS = 1'b0;
  localparam logic ST_OOR  = 1'b1;

  // fixed parts of a mask word: upper address bits all ones, valid flag at bit 11
  localparam logic [DATA_W-1:0] MASK_HIGH  = 48'hFFFF_0000_0000;
  localparam logic [DATA_W-1:0] VALID_FLAG = 48'h0000_0000_0800;
  localparam int unsigned       REPORT_MAX = 10;

  // one register write as the block should present it
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
    logic              status;
  } mtrr_write_t;

  // Predicts the base/mask write sequence of each accepted request and checks
  // every result write against the oldest predicted one.
  class mtrr_write_tracker;
    logic [TYPE_W-1:0] mem_type;
    mtrr_write_t       pending_writes[$];
    int unsigned       mismatches;
    int unsigned       n_requests;
    int unsigned       n_writes;
    int unsigned       n_oor;
    int unsigned       n_zero;

    function new();
      mem_type   = MEM_TYPE_RST;
      mismatches = 0;
      n_requests = 0;
      n_writes   = 0;
      n_oor      = 0;
      n_zero     = 0;
    endfunction

    // Greedy cover of [0, top): one region per pass, at most NUM_PAIRS-1 regions.
    function void note_request(logic [TOM_W-1:0] tom);
      int unsigned top;
      int unsigned base;
      int unsigned size;
      int unsigned rem;
      int unsigned pair;
      int unsigned b;
      mtrr_write_t w;
      top  = tom;
      base = 0;
      pair = 0;
      n_requests++;
      if (top == 0) n_zero++;
      while (pair < NUM_PAIRS - 1 && base < top) begin
        // natural alignment of the base decides the size first
        size = 32'h8000_0000;
        for (b = 0; b < 31; b++) begin
          if (base[b]) begin
            size = 32'd1 << b;
            break;
          end
        end
        // zero base or overshoot: take the top bit of what is left
        if (base == 0 || base + size > top) begin
          rem = top - base;
          for (b = 0; b < 32; b++) begin
            if (rem[b]) size = 32'd1 << b;
          end
        end
        w.addr   = ADDR_FIRST + ADDR_W'(2 * pair);
        w.data   = (DATA_W'(base) << 16) | DATA_W'(mem_type);
        w.last   = 1'b0;
        w.status = ST_PASS;
        pending_writes.push_back(w);
        w.addr = ADDR_FIRST + ADDR_W'(2 * pair + 1);
        w.data = MASK_HIGH | (DATA_W'(~(size - 1) & 32'hFFFF) << 16) | VALID_FLAG;
        pending_writes.push_back(w);
        base += size;
        pair++;
      end
      if (base < top) begin
        n_oor++;
        pending_writes[pending_writes.size() - 1].last   = 1'b1;
        pending_writes[pending_writes.size() - 1].status = ST_OOR;
        return;
      end
      // covered: clear what is left, mask before base
      while (pair < NUM_PAIRS) begin
        w.addr   = ADDR_FIRST + ADDR_W'(2 * pair + 1);
        w.data   = '0;
        w.last   = 1'b0;
        w.status = ST_PASS;
        pending_writes.push_back(w);
        w.addr = ADDR_FIRST + ADDR_W'(2 * pair);
        pending_writes.push_back(w);
        pair++;
      end
      pending_writes[pending_writes.size() - 1].last = 1'b1;
    endfunction

    function void check_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                              logic last, logic status);
      mtrr_write_t want;
      n_writes++;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: write with nothing expected: addr %h data %h last %b status %b",
                   $realtime, addr, data, last, status);
        return;
      end
      want = pending_writes.pop_front();
      if (addr !== want.addr || data !== want.data || last !== want.last ||
          status !== want.status) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: write mismatch", $realtime);
          $display("  expected addr %h data %h last %b status %b",
                   want.addr, want.data, want.last, want.status);
          $display("  actual   addr %h data %h last %b status %b",
                   addr, data, last, status);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [TOM_W-1:0]  in_tom_units;
  logic              out_valid;
  logic              out_ready;
  logic [ADDR_W-1:0] out_reg_addr;
  logic [DATA_W-1:0] out_reg_data;
  logic              out_run_last;
  logic              out_status;
  logic              cfg_we;
  logic [TYPE_W-1:0] cfg_mem_type;

  // idle odds in percent for the sender and the receiver
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  int unsigned cfg_settings;

  mtrr_write_tracker tracker = new();

  // Directed tops: zero, single units, full range, single regions, exactly
  // seven regions (covered, one pair cleared), eight regions (out of pairs),
  // alternating bits and bases whose alignment overshoots the top.
  logic [TOM_W-1:0] directed_tops [20] = '{
    16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'hFFFF,
    16'h8000, 16'h8001, 16'h7FFF, 16'h007F, 16'h00FF,
    16'hFE00, 16'hFF00, 16'h5555, 16'hAAAA, 16'h1234,
    16'h00FE, 16'hC000, 16'h0180, 16'hFFFE, 16'h4000
  };

  mtrr_range_decomposer_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_tom_units (in_tom_units),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_reg_addr (out_reg_addr),
    .out_reg_data (out_reg_data),
    .out_run_last (out_run_last),
    .out_status   (out_status),
    .cfg_we       (cfg_we),
    .cfg_mem_type (cfg_mem_type)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready is redrawn every falling edge, writes are taken at the
  // rising edge when valid and ready are both high.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_write(out_reg_addr, out_reg_data, out_run_last, out_status);
  end

  // Mostly sparse tops (seven set bits or fewer) so that runs reach the
  // clearing pass; the rest are full-width, tiny, near powers of two, or zero.
  function automatic logic [TOM_W-1:0] random_top();
    int unsigned      pick;
    logic [TOM_W-1:0] v;
    pick = $urandom_range(99);
    v    = '0;
    if (pick < 55) begin
      repeat ($urandom_range(1, 7)) v[$urandom_range(TOM_W - 1)] = 1'b1;
    end else if (pick < 80) begin
      v = TOM_W'($urandom);
    end else if (pick < 88) begin
      v = TOM_W'($urandom_range(1, 9));
    end else if (pick < 97) begin
      v = (TOM_W'(1) << $urandom_range(TOM_W - 1)) + TOM_W'($urandom_range(0, 2)) - 1'b1;
    end
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Valid stays up after return so back-to-back requests need no re-raise.
  task automatic send_request(input logic [TOM_W-1:0] tom);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_tom_units <= tom;
    do @(posedge clk); while (!(in_valid && in_ready));
    tracker.note_request(tom);
    @(negedge clk);
  endtask

  // Hold off new requests until every predicted write has come back; the
  // block is then idle and safe for a config write.
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (tracker.pending_writes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mem_type(input logic [TYPE_W-1:0] code);
    cfg_we       <= 1'b1;
    cfg_mem_type <= code;
    @(posedge clk);
    tracker.mem_type = code;
    cfg_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned gap,
                           input int unsigned stall);
    in_gap_pct    = gap;
    out_stall_pct = stall;
    repeat (n) send_request(random_top());
    drain_requests();
  endtask

  initial begin
    int unsigned waited;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_tom_units  = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_mem_type  = MEM_TYPE_RST;
    in_gap_pct    = 0;
    out_stall_pct = 0;
    cfg_settings  = 1;
    waited        = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests under the reset memory type, light receiver stalls
    out_stall_pct = 30;
    foreach (directed_tops[i]) send_request(directed_tops[i]);
    drain_requests();

    // random phases, each under its own memory type, extremes first
    write_mem_type('0);
    run_phase(120, 20, 62);
    write_mem_type('1);
    run_phase(120, 62, 20);
    write_mem_type(TYPE_W'($urandom_range(1, 5)));
    run_phase(125, 0, 0);

    // everything is drained; let any trailing activity show up, bounded
    while (tracker.pending_writes.size() != 0 && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (tracker.pending_writes.size() != 0) begin
      tracker.mismatches += tracker.pending_writes.size();
      $display("%0d predicted writes never arrived", tracker.pending_writes.size());
    end

    $display("Covered %0d requests (%0d zero tops, %0d out of pairs), %0d writes checked,",
             tracker.n_requests, tracker.n_zero, tracker.n_oor, tracker.n_writes);
    $display("under %0d memory type settings; %0d mismatches.",
             cfg_settings, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("mtrr_range_decomposer_unit verification clean");
    end else begin
      $display("mtrr_range_decomposer_unit verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("mtrr_range_decomposer_unit verification failed");
    $finish;
  end

endmodule
